[rtl/lle_pkg.sv]
// ----------------------------------------------------------------------------
// lle_pkg
// Item types and codes shared by the linked list table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lle_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/lle_ram.sv]
// ----------------------------------------------------------------------------
// lle_ram
// Simple dual-port synchronous memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/linked_list_table_engine.sv]
// ----------------------------------------------------------------------------
// linked_list_table_engine
// Singly linked list of signed 32-bit values in a node store with a free stack.
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per request (opcode, key, new_value), taken while
//   the engine is idle. rsp channel: one item per request (status, slot,
//   entry_count), held in an output register until taken.
//   insert: one free stack read and one node write, then the result goes to the
//   output register. search, modify, delete: the walk visits nodes from the head,
//   each node a node memory read, then a compare, and at most CAPACITY nodes
//   are visited before the result goes to the output register.
//   the next request is taken as soon as the result is in the output
//   register; if the receiver stalls with a result still held, the engine
//   finishes its current request and then waits for the output register.
//   reset empties the list: head null, all slots free, handed out from 0 up.
//   the free stack keeps a low-water mark, so reset needs no memory sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_table_engine
  import lle_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_CHECK,
    S_RESP
  } state_t;

  state_t state;

  logic [1:0]    op_q;
  logic [31:0]   key_q;
  logic [31:0]   nv_q;
  logic [LW-1:0] head;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic [CW-1:0] steps;
  logic [CW-1:0] free_count;
  logic [CW-1:0] free_low;
  logic [CW-1:0] list_count;
  logic [1:0]    res_status;
  logic [AW-1:0] res_slot;

  logic          val_we;
  logic [AW-1:0] val_waddr;
  logic [31:0]   val_wdata;
  logic [31:0]   val_rdata;
  logic          lnk_we;
  logic [AW-1:0] lnk_waddr;
  logic [LW-1:0] lnk_wdata;
  logic [LW-1:0] lnk_rdata;
  logic          fs_we;
  logic [AW-1:0] fs_waddr;
  logic [AW-1:0] fs_wdata;
  logic [AW-1:0] fs_raddr;
  logic [AW-1:0] fs_rdata;

  logic [AW-1:0] pop_idx;
  logic [AW-1:0] pop_raw;
  logic [AW-1:0] pop_slot;
  logic [CW-1:0] fc_dec;
  logic          match;

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(32), .AW(AW)) u_value (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (cur[AW-1:0]),
    .rdata (val_rdata)
  );

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(LW), .AW(AW)) u_link (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (cur[AW-1:0]),
    .rdata (lnk_rdata)
  );

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(AW), .AW(AW)) u_free (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign fc_dec    = free_count - CW'(1);
  assign pop_idx   = fc_dec[AW-1:0];
  assign fs_raddr  = pop_idx;
  assign match     = (val_rdata == key_q);

  // entries below the low-water mark were never written; their reset contents are computed here
  always_comb begin
    if (CW'(pop_idx) < free_low) begin
      pop_raw = AW'(CAPACITY - 1) - pop_idx;
    end else begin
      pop_raw = fs_rdata;
    end
    if (LW'(pop_raw) >= NULL_LINK) begin
      pop_slot = '0;
    end else begin
      pop_slot = pop_raw;
    end
  end

  always_comb begin
    val_we    = 1'b0;
    val_waddr = cur[AW-1:0];
    val_wdata = nv_q;
    lnk_we    = 1'b0;
    lnk_waddr = prev[AW-1:0];
    lnk_wdata = lnk_rdata;
    fs_we     = 1'b0;
    fs_waddr  = free_count[AW-1:0];
    fs_wdata  = cur[AW-1:0];
    case (state)
      S_POP: begin
        val_we    = 1'b1;
        val_waddr = pop_slot;
        val_wdata = key_q;
        lnk_we    = 1'b1;
        lnk_waddr = pop_slot;
        lnk_wdata = head;
      end
      S_CHECK: begin
        if (match) begin
          val_we = (op_q == OP_MODIFY);
          if (op_q == OP_DELETE) begin
            lnk_we = (prev < NULL_LINK);
            fs_we  = (free_count < CAP_CNT);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      head       <= NULL_LINK;
      free_count <= CAP_CNT;
      free_low   <= CAP_CNT;
      list_count <= '0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q  <= req.opcode;
            key_q <= req.key;
            nv_q  <= req.new_value;
            cur   <= head;
            prev  <= NULL_LINK;
            steps <= '0;
            if (req.opcode == OP_INSERT) begin
              if (free_count == '0) begin
                res_status <= ST_FULL;
                res_slot   <= '0;
                state      <= S_RESP;
              end else begin
                state <= S_POP;
              end
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_POP: begin
          head       <= LW'(pop_slot);
          free_count <= fc_dec;
          if (fc_dec < free_low) begin
            free_low <= fc_dec;
          end
          list_count <= list_count + CW'(1);
          res_status <= ST_OK;
          res_slot   <= pop_slot;
          state      <= S_RESP;
        end
        S_WALK: begin
          if (cur >= NULL_LINK || steps == CAP_CNT) begin
            res_status <= ST_NOT_FOUND;
            res_slot   <= '0;
            state      <= S_RESP;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (match) begin
            res_status <= ST_OK;
            res_slot   <= cur[AW-1:0];
            if (op_q == OP_DELETE) begin
              if (prev >= NULL_LINK) begin
                head <= lnk_rdata;
              end
              if (free_count < CAP_CNT) begin
                free_count <= free_count + CW'(1);
              end
              if (list_count != '0) begin
                list_count <= list_count - CW'(1);
              end
            end
            state <= S_RESP;
          end else begin
            prev  <= cur;
            cur   <= lnk_rdata;
            steps <= steps + CW'(1);
            state <= S_WALK;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.slot        <= SLOT_W'(res_slot);
            rsp.entry_count <= COUNT_W'(list_count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sim/linked_list_table_engine_tb.sv]
// ----------------------------------------------------------------------------
// linked_list_table_engine_tb
// Self-checking bench for the linked list table engine. A shadow copy of the
// node store, links, head, free stack and entry count predicts the responses; typed rows give their own.
// Directed rows cover the empty list, the key extremes, duplicates, and
// deletes at the head, in the middle and at the tail. Random phases then fill
// the store past full, drain it and mix lookups over a small key pool, with
// random idling on both channels, a long response stall and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module linked_list_table_engine_tb;
  import lle_pkg::*;

  localparam int CAP = 64;
  localparam int RANDOM_ITEMS = 1430;
  localparam int HOLD_CYCLES = 300;

  localparam int PH_FILL   = 0;
  localparam int PH_MIX    = 1;
  localparam int PH_DRAIN  = 2;
  localparam int PH_LOOKUP = 3;

  localparam logic signed [31:0] KEY_MIN  = 32'sh80000000;
  localparam logic signed [31:0] KEY_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] KEY_PAT5 = 32'sh55555555;
  localparam logic signed [31:0] KEY_PATA = 32'shAAAAAAAA;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // typed expectation travels alongside the item being offered
  bit   row_typed;
  rsp_t row_want;

  // shadow list state
  logic signed [31:0] node_val [CAP];
  logic [6:0]         node_next [CAP];
  logic [5:0]         free_slots [CAP];
  logic [6:0]         head;
  logic [6:0]         free_depth;
  logic [6:0]         live;

  rsp_t     list_result_q[$];
  dir_row_t dir_rows[$];
  logic signed [31:0] key_pool [16];

  int  n_accepted;
  int  n_errors;
  int  op_seen [4];
  int  n_ok, n_miss, n_full, peak_live;
  bit  quiet;

  linked_list_table_engine #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("linked_list_table_engine_tb: FAIL");
    $finish;
  end

  task automatic apply_list_op(input req_t r, output rsp_t res);
    logic [6:0] cur;
    logic [6:0] prev;
    logic [5:0] s;
    bit         hit;
    res = '0;
    res.status = ST_OK;
    if (r.opcode == OP_INSERT) begin
      if (free_depth == 0) begin
        res.status = ST_FULL;
      end else begin
        free_depth = free_depth - 7'd1;
        s = free_slots[free_depth[5:0]];
        node_val[s] = r.key;
        node_next[s] = head;
        head = {1'b0, s};
        live = live + 7'd1;
        res.slot = s;
      end
    end else begin
      cur = head;
      prev = 7'(CAP);
      hit = 1'b0;
      for (int i = 0; i < CAP; i++) begin
        if (!hit && cur < CAP) begin
          if (node_val[cur[5:0]] == r.key) begin
            hit = 1'b1;
          end else begin
            prev = cur;
            cur = node_next[cur[5:0]];
          end
        end
      end
      if (!hit) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.slot = cur[5:0];
        if (r.opcode == OP_MODIFY) begin
          node_val[cur[5:0]] = r.new_value;
        end else if (r.opcode == OP_DELETE) begin
          if (prev == CAP) head = node_next[cur[5:0]];
          else node_next[prev[5:0]] = node_next[cur[5:0]];
          free_slots[free_depth[5:0]] = cur[5:0];
          free_depth = free_depth + 7'd1;
          live = live - 7'd1;
        end
      end
    end
    res.entry_count = live;
    if (live > peak_live) peak_live = int'(live);
  endtask

  // request and response monitor
  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (req_valid && req_ready) begin
        apply_list_op(req, want);
        if (row_typed) want = row_want;
        list_result_q.push_back(want);
        op_seen[req.opcode]++;
        n_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        got = rsp;
        if (list_result_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected item status=%0d slot=%0d count=%0d", $time,
                   got.status, got.slot, got.entry_count);
        end else begin
          want = list_result_q.pop_front();
          if (want.status == ST_OK) n_ok++;
          else if (want.status == ST_NOT_FOUND) n_miss++;
          else n_full++;
          if (got.status !== want.status) begin
            n_errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.slot !== want.slot) begin
            n_errors++;
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
          end
          if (got.entry_count !== want.entry_count) begin
            n_errors++;
            $display("%0t: entry_count expected %0d, got %0d", $time,
                     want.entry_count, got.entry_count);
          end
        end
      end
    end
  end

  // response side: random stalls plus one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !held && n_accepted >= 500) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= !rst && (quiet || $urandom_range(0, 99) >= 11);
    end
  end

  task automatic add_row(input logic [1:0] op, input logic signed [31:0] key,
                         input logic signed [31:0] nv, input bit typed,
                         input logic [1:0] st, input int slot, input int cnt);
    dir_row_t row;
    row.item.opcode = op;
    row.item.key = key;
    row.item.new_value = nv;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = SLOT_W'(slot);
    row.want.entry_count = COUNT_W'(cnt);
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input req_t item, input bit typed, input rsp_t want);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[4'($urandom_range(0, 15))];
    return $urandom;
  endfunction

  function automatic req_t make_item(input int kind);
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    case (kind)
      PH_FILL: begin
        r.opcode = roll < 70 ? OP_INSERT : roll < 80 ? OP_SEARCH :
                   roll < 90 ? OP_MODIFY : OP_DELETE;
      end
      PH_DRAIN: begin
        r.opcode = roll < 10 ? OP_INSERT : roll < 25 ? OP_SEARCH :
                   roll < 40 ? OP_MODIFY : OP_DELETE;
      end
      PH_LOOKUP: begin
        r.opcode = roll < 20 ? OP_INSERT : roll < 60 ? OP_SEARCH :
                   roll < 90 ? OP_MODIFY : OP_DELETE;
      end
      default: begin
        r.opcode = roll < 25 ? OP_INSERT : roll < 50 ? OP_SEARCH :
                   roll < 75 ? OP_MODIFY : OP_DELETE;
      end
    endcase
    r.key = pick_key();
    if (r.opcode == OP_MODIFY && $urandom_range(0, 99) < 60) r.new_value = pick_key();
    else r.new_value = $urandom;
    return r;
  endfunction

  initial begin : sender
    int   n_rand;
    int   phase;
    int   plen;
    rsp_t none;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    row_typed = 1'b0;
    row_want = '0;
    quiet = 1'b0;
    none = '0;
    n_accepted = 0;
    n_errors = 0;
    n_ok = 0;
    n_miss = 0;
    n_full = 0;
    peak_live = 0;
    for (int i = 0; i < 4; i++) op_seen[i] = 0;
    head = 7'(CAP);
    free_depth = 7'(CAP);
    live = '0;
    for (int i = 0; i < CAP; i++) free_slots[i] = 6'(CAP - 1 - i);

    key_pool[0] = 32'sd0;
    key_pool[1] = -32'sd1;
    key_pool[2] = KEY_MIN;
    key_pool[3] = KEY_MAX;
    key_pool[4] = KEY_PAT5;
    key_pool[5] = KEY_PATA;
    key_pool[6] = 32'sd1;
    for (int i = 7; i < 16; i++) key_pool[i] = $urandom;

    add_row(OP_SEARCH, 32'sd0, 32'sd0, 1'b1, ST_NOT_FOUND, 0, 0);
    add_row(OP_MODIFY, 32'sd5, 32'sd7, 1'b1, ST_NOT_FOUND, 0, 0);
    add_row(OP_DELETE, -32'sd1, 32'sd0, 1'b1, ST_NOT_FOUND, 0, 0);
    add_row(OP_INSERT, KEY_MIN, -32'sd1, 1'b1, ST_OK, 0, 1);
    add_row(OP_INSERT, KEY_MAX, 32'sd0, 1'b1, ST_OK, 1, 2);
    add_row(OP_INSERT, 32'sd0, KEY_MAX, 1'b1, ST_OK, 2, 3);
    add_row(OP_INSERT, -32'sd1, KEY_MIN, 1'b1, ST_OK, 3, 4);
    add_row(OP_INSERT, KEY_MAX, 32'sd0, 1'b1, ST_OK, 4, 5);
    add_row(OP_SEARCH, KEY_MAX, 32'sd0, 1'b1, ST_OK, 4, 5);
    add_row(OP_SEARCH, KEY_MIN, 32'sd0, 1'b1, ST_OK, 0, 5);
    add_row(OP_MODIFY, KEY_MAX, KEY_PAT5, 1'b0, ST_OK, 0, 0);
    add_row(OP_SEARCH, KEY_MAX, -32'sd1, 1'b0, ST_OK, 0, 0);
    add_row(OP_SEARCH, KEY_PAT5, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_DELETE, -32'sd1, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_DELETE, KEY_PAT5, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_DELETE, KEY_MIN, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_SEARCH, KEY_MIN, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_INSERT, KEY_PATA, KEY_PAT5, 1'b0, ST_OK, 0, 0);
    add_row(OP_DELETE, KEY_MAX, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_DELETE, KEY_MAX, 32'sd0, 1'b0, ST_OK, 0, 0);
    add_row(OP_MODIFY, 32'sd0, KEY_MIN, 1'b0, ST_OK, 0, 0);
    add_row(OP_SEARCH, KEY_MIN, KEY_PATA, 1'b0, ST_OK, 0, 0);

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    n_rand = 0;
    phase = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if (phase % 2 == 1) begin
        // let every owed item come back before the next phase
        req_valid <= 1'b0;
        while (list_result_q.size() != 0) @(negedge clk);
      end
      quiet = (phase == 2);
      plen = $urandom_range(80, 140);
      for (int k = 0; k < plen && n_rand < RANDOM_ITEMS; k++) begin
        send_item(make_item(phase % 4), 1'b0, none);
        n_rand++;
      end
      phase++;
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    while (list_result_q.size() != 0) @(negedge clk);
    repeat (2 * CAP + 8) @(negedge clk);

    $display("ran %0d requests: %0d insert, %0d search, %0d modify, %0d delete",
             n_accepted, op_seen[OP_INSERT], op_seen[OP_SEARCH], op_seen[OP_MODIFY],
             op_seen[OP_DELETE]);
    $display("results: %0d ok, %0d not found, %0d full; deepest list %0d entries",
             n_ok, n_miss, n_full, peak_live);
    if (n_errors == 0 && list_result_q.size() == 0) begin
      $display("linked_list_table_engine_tb: PASS");
    end else begin
      $display("linked_list_table_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

[linked_list_table_engine.f]
rtl/lle_pkg.sv
rtl/lle_ram.sv
rtl/linked_list_table_engine.sv
sim/linked_list_table_engine_tb.sv
